### hdl/ktc_pkg.sv
// ----------------------------------------------------------------------------
// ktc_pkg: shared types and constants of the keyed table
// Command codes, field widths, the command and response transfer types, and
// the register map of the configuration port.
// ----------------------------------------------------------------------------
package ktc_pkg;

	localparam int KEY_W           = 32;
	localparam int VAL_W           = 32;
	localparam int CMD_W           = 3;
	localparam int POS_W           = 6;
	localparam int CNT_OUT_W       = 7;
	localparam int CAP_W           = 7;
	localparam int APB_AW          = 3;
	localparam int APB_DW          = 32;
	localparam int DEF_MAX_ENTRIES = 64;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Register index of the capacity register.
	localparam logic REG_CAPACITY = 1'b0;

	// Command codes. Codes 6 and 7 are unused and change nothing.
	localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UPDATE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_UPSERT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ERASE    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ_POS = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [POS_W-1:0] position;
	} cmd_item_t;

	typedef struct packed {
		logic                 ok;
		logic [KEY_W-1:0]     found_key;
		logic [VAL_W-1:0]     found_value;
		logic [CNT_OUT_W-1:0] entry_count;
	} rsp_item_t;

endpackage

### hdl/ktc_ram.sv
// ----------------------------------------------------------------------------
// ktc_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module ktc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/ktc_ctrl.sv
// ----------------------------------------------------------------------------
// ktc_ctrl: command sequencer of the keyed table
// Scans the entry RAM for a key or reads one position, applies the command,
// compacts the table on erase and hands one response to the output stage.
// ----------------------------------------------------------------------------
module ktc_ctrl #(
	parameter int MAX_ENTRIES = ktc_pkg::DEF_MAX_ENTRIES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ktc_pkg::CAP_W-1:0] capacity,
	input  logic                      cmd_valid,
	input  ktc_pkg::cmd_item_t        cmd,
	output logic                      cmd_stall,
	input  logic                      rsp_free,
	output logic                      rsp_valid,
	output ktc_pkg::rsp_item_t        rsp
);

	import ktc_pkg::*;

	localparam int AW     = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int POSC_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int MEM_W  = KEY_W + VAL_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_SHIFT,
		ST_READ,
		ST_DONE
	} state_t;

	state_t           state_q;
	cmd_item_t        cmd_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] ptr_q;
	logic             pend_s1;
	logic [CNT_W-1:0] idx_s1;
	logic             hit_q;
	logic [CNT_W-1:0] hit_idx_q;
	logic [VAL_W-1:0] hit_val_q;
	logic             ok_q;
	logic [KEY_W-1:0] fk_q;
	logic [VAL_W-1:0] fv_q;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [MEM_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr;
	logic [MEM_W-1:0] mem_rdata;

	logic [KEY_W-1:0] rd_key;
	logic [VAL_W-1:0] rd_val;
	logic             match;
	logic             issue;
	logic             room;
	logic             pos_ok;

	ktc_ram #(
		.WIDTH(MEM_W),
		.DEPTH(MAX_ENTRIES)
	) u_entries (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rd_key = mem_rdata[MEM_W-1 -: KEY_W];
	assign rd_val = mem_rdata[VAL_W-1:0];
	assign match  = pend_s1 && (rd_key == cmd_q.key);
	assign issue  = ptr_q < used_q;
	assign room   = (CMP_W'(used_q) < CMP_W'(capacity)) &&
	                (CMP_W'(used_q) < CMP_W'(MAX_ENTRIES));
	assign pos_ok = POSC_W'(cmd_q.position) < POSC_W'(used_q);

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = (state_q == ST_DONE);

	always_comb begin
		rsp.ok          = ok_q;
		rsp.found_key   = fk_q;
		rsp.found_value = fv_q;
		rsp.entry_count = CNT_OUT_W'(used_q);
	end

	// The positional read is issued while the command is accepted.
	assign mem_raddr = (state_q == ST_IDLE) ? AW'(cmd.position) : AW'(ptr_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(hit_idx_q);
		mem_wdata = {cmd_q.key, cmd_q.value};
		unique case (state_q)
			ST_APPLY: begin
				case (cmd_q.command)
					CMD_INSERT, CMD_UPSERT: begin
						if (hit_q) begin
							mem_we = (cmd_q.command == CMD_UPSERT);
						end else if (room) begin
							mem_we    = 1'b1;
							mem_waddr = AW'(used_q);
						end
					end
					CMD_UPDATE: begin
						mem_we = hit_q;
					end
					default: begin
						mem_we = 1'b0;
					end
				endcase
			end
			ST_SHIFT: begin
				// Each entry read in the previous cycle moves down by one place.
				mem_we    = pend_s1;
				mem_waddr = AW'(idx_s1 - 1'b1);
				mem_wdata = mem_rdata;
			end
			ST_IDLE, ST_SCAN, ST_READ, ST_DONE: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			ptr_q     <= '0;
			pend_s1   <= 1'b0;
			hit_q     <= 1'b0;
			cmd_q     <= '0;
			idx_s1    <= '0;
			hit_idx_q <= '0;
			hit_val_q <= '0;
			ok_q      <= 1'b0;
			fk_q      <= '0;
			fv_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						ptr_q   <= '0;
						pend_s1 <= 1'b0;
						hit_q   <= 1'b0;
						ok_q    <= 1'b0;
						fk_q    <= '0;
						fv_q    <= '0;
						if (cmd.command == CMD_READ_POS) begin
							state_q <= ST_READ;
						end else if (cmd.command <= CMD_LOOKUP) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (match) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_s1;
						hit_val_q <= rd_val;
						pend_s1   <= 1'b0;
						state_q   <= ST_APPLY;
					end else if (!pend_s1 && !issue) begin
						state_q <= ST_APPLY;
					end else begin
						pend_s1 <= issue;
						idx_s1  <= ptr_q;
						if (issue) begin
							ptr_q <= CNT_W'(ptr_q + 1'b1);
						end
					end
				end
				ST_APPLY: begin
					state_q <= ST_DONE;
					case (cmd_q.command)
						CMD_INSERT, CMD_UPSERT: begin
							if (hit_q) begin
								ok_q <= (cmd_q.command == CMD_UPSERT);
							end else if (room) begin
								ok_q   <= 1'b1;
								used_q <= CNT_W'(used_q + 1'b1);
							end
						end
						CMD_UPDATE: begin
							ok_q <= hit_q;
						end
						CMD_ERASE: begin
							if (hit_q) begin
								ptr_q   <= CNT_W'(hit_idx_q + 1'b1);
								pend_s1 <= 1'b0;
								state_q <= ST_SHIFT;
							end
						end
						CMD_LOOKUP: begin
							ok_q <= hit_q;
							fv_q <= hit_q ? hit_val_q : '0;
						end
						default: begin
							ok_q <= 1'b0;
						end
					endcase
				end
				ST_SHIFT: begin
					if (!pend_s1 && !issue) begin
						used_q  <= CNT_W'(used_q - 1'b1);
						ok_q    <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						pend_s1 <= issue;
						idx_s1  <= ptr_q;
						if (issue) begin
							ptr_q <= CNT_W'(ptr_q + 1'b1);
						end
					end
				end
				ST_READ: begin
					ok_q    <= pos_ok;
					fk_q    <= pos_ok ? rd_key : '0;
					fv_q    <= pos_ok ? rd_val : '0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/keyed_table_with_compaction.sv
// ----------------------------------------------------------------------------
// keyed_table_with_compaction: key/value table of unique keys in insert order
// Top level with the configuration port, the command sequencer and the
// response register.
// ----------------------------------------------------------------------------
// The table holds up to MAX_ENTRIES key/value pairs in one RAM, packed at the
// low positions in the order they were inserted. One command is in work at a
// time. A key search reads one entry per cycle in a pipelined scan over the
// held entries. Erase then compacts the table, moving each later entry down
// one place at one entry per cycle. A new command is taken as soon as the
// previous response has moved into the response register, so a finished
// response may wait there while the next command is already at work. The
// capacity register at byte address 0 limits how many entries an insert may
// create; it resets to 64 and values above MAX_ENTRIES act as MAX_ENTRIES.
// The RAM is not cleared at reset: only data from positions that were
// written is ever used.
// ----------------------------------------------------------------------------
module keyed_table_with_compaction #(
	parameter int MAX_ENTRIES = ktc_pkg::DEF_MAX_ENTRIES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration port.
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ktc_pkg::APB_AW-1:0] paddr,
	input  logic [ktc_pkg::APB_DW-1:0] pwdata,
	output logic [ktc_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	// Command channel.
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  ktc_pkg::cmd_item_t         cmd,
	// Response channel.
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output ktc_pkg::rsp_item_t         rsp
);

	import ktc_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             reg_sel;
	logic             cfg_write;

	logic             seq_rsp_valid;
	rsp_item_t        seq_rsp;
	logic             rsp_free;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	// Registers sit at byte addresses 4*i, so the word index is paddr[2].
	assign reg_sel   = paddr[2];
	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_write && (reg_sel == REG_CAPACITY)) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (reg_sel == REG_CAPACITY) ? APB_DW'(capacity_q) : '0;

	// The sequencer owns the entry RAM and the entry count.
	ktc_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (capacity_q),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_stall(cmd_stall),
		.rsp_free (rsp_free),
		.rsp_valid(seq_rsp_valid),
		.rsp      (seq_rsp)
	);

	// The response register is free when it is empty or its transfer
	// completes in this cycle, so the sequencer never waits on a held
	// response longer than the downstream stall lasts.
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_free) begin
			rsp_valid_q <= seq_rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_free && seq_rsp_valid) begin
			rsp_q <= seq_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### tb/keyed_table_with_compaction_tb.sv
// ----------------------------------------------------------------------------
// keyed_table_with_compaction_tb: self-checking bench of the keyed table
// Sends commands through the valid/stall channel, predicts every response
// from a shadow copy of the table and the capacity register, and compares
// each response field by field. Directed cases come first, then random
// phases under several capacity settings, then a long response hold-off.
// ----------------------------------------------------------------------------
module keyed_table_with_compaction_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ktc_pkg::*;

	// Command codes 6 and 7 are not used by the block; it must answer them
	// without touching the table.
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	// Byte address of the capacity register on the configuration port.
	localparam logic [APB_AW-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

	// Mixes of commands used by the random phases.
	localparam int BIAS_FILL  = 0;
	localparam int BIAS_MIX   = 1;
	localparam int BIAS_DRAIN = 2;

	localparam int KEY_POOL_SIZE = 80;
	localparam int MAX_GAP       = 13;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 150;

	typedef struct packed {
		cmd_item_t item;
		rsp_item_t rsp;
	} answer_rec_t;

	logic            clk;
	logic            arst_n;
	logic            psel;
	logic            penable;
	logic            pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic            pready;
	logic            cmd_valid;
	logic            cmd_stall;
	cmd_item_t       cmd;
	logic            rsp_valid;
	logic            rsp_stall;
	rsp_item_t       rsp;

	keyed_table_with_compaction DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Shadow of the table as it stands after every command accepted so far.
	// Entries at and above shadow_fill are never looked at.
	logic [KEY_W-1:0] shadow_keys [DEF_MAX_ENTRIES];
	logic [VAL_W-1:0] shadow_vals [DEF_MAX_ENTRIES];
	int               shadow_fill;
	logic [CAP_W-1:0] shadow_cap;

	// Responses the block still owes, oldest first.
	answer_rec_t pending_answers[$];

	// A small set of keys that random commands keep returning to, so that
	// duplicates, hits and misses all happen often.
	logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

	int mismatches;
	int responses_seen;

	// Pacing controls. A calm side does not idle at all; the sender burst
	// flag forces back-to-back commands; hold_cycles asks the response side
	// for one long stall.
	bit send_calm;
	bit sink_calm;
	bit send_burst;
	int hold_cycles;

	always #5 clk = ~clk;

	// Watchdog: far beyond the slowest legal run of every phase.
	initial begin : watchdog
		#8_000_000;
		$display("keyed_table_with_compaction verification failed");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("%0t ns: mismatch: %s", $realtime, what);
	endtask

	function automatic int pick_gap(input bit calm);
		if (calm)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	// Works out the response to one command and applies the command to the
	// shadow table. The search mirrors the block: first entry holding the key,
	// or shadow_fill when no entry holds it.
	function automatic rsp_item_t table_answer(input cmd_item_t c);
		rsp_item_t r;
		int        hit;
		int        room;
		r = '0;
		hit = shadow_fill;
		for (int i = shadow_fill - 1; i >= 0; i--)
			if (shadow_keys[i] == c.key)
				hit = i;
		room = (shadow_cap > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : int'(shadow_cap);
		case (c.command)
			CMD_INSERT, CMD_UPSERT: begin
				if (hit < shadow_fill) begin
					// A duplicate key: plain insert refuses, upsert rewrites.
					if (c.command == CMD_UPSERT) begin
						shadow_vals[hit] = c.value;
						r.ok = 1'b1;
					end
				end else if (shadow_fill < room) begin
					shadow_keys[shadow_fill] = c.key;
					shadow_vals[shadow_fill] = c.value;
					shadow_fill++;
					r.ok = 1'b1;
				end
			end
			CMD_UPDATE: begin
				if (hit < shadow_fill) begin
					shadow_vals[hit] = c.value;
					r.ok = 1'b1;
				end
			end
			CMD_ERASE: begin
				if (hit < shadow_fill) begin
					// Later entries close the gap so insertion order is kept.
					for (int j = hit; j + 1 < shadow_fill; j++) begin
						shadow_keys[j] = shadow_keys[j + 1];
						shadow_vals[j] = shadow_vals[j + 1];
					end
					shadow_fill--;
					r.ok = 1'b1;
				end
			end
			CMD_LOOKUP: begin
				if (hit < shadow_fill) begin
					r.found_value = shadow_vals[hit];
					r.ok = 1'b1;
				end
			end
			CMD_READ_POS: begin
				if (int'(c.position) < shadow_fill) begin
					r.found_key   = shadow_keys[c.position];
					r.found_value = shadow_vals[c.position];
					r.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.entry_count = shadow_fill[CNT_OUT_W-1:0];
		return r;
	endfunction

	// Offers one command after a random idle gap and records the expected
	// response once the transfer takes place. Valid is left high afterwards
	// so that a following command can go out back to back; wait_drained
	// lowers it when the sender stops.
	task automatic send_cmd(input cmd_item_t item);
		int gap;
		answer_rec_t rec;
		if ($urandom_range(0, 39) == 0)
			send_calm = ~send_calm;
		gap = send_burst ? 0 : pick_gap(send_calm);
		@(negedge clk);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= item;
		do @(posedge clk); while (cmd_stall);
		rec.item = item;
		rec.rsp  = table_answer(item);
		pending_answers.push_back(rec);
	endtask

	task automatic send_fields(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v, input logic [POS_W-1:0] p);
		cmd_item_t c;
		c.command  = op;
		c.key      = k;
		c.value    = v;
		c.position = p;
		send_cmd(c);
	endtask

	// Stops offering commands and waits until every response has come back.
	// The block is idle after that, so the capacity register may be written.
	task automatic wait_drained();
		if (cmd_valid) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
		end
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the
	// edge where psel, penable, pwrite and pready are all high.
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= CAPACITY_ADDR;
		pwdata  <= APB_DW'(cap);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		shadow_cap = cap;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Keys come mostly from the table itself or from the pool, now and then
	// a fresh random word.
	function automatic logic [KEY_W-1:0] pick_key(input int present_pct);
		if (shadow_fill > 0 && $urandom_range(0, 99) < present_pct)
			return shadow_keys[$urandom_range(0, shadow_fill - 1)];
		if ($urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
		return $urandom();
	endfunction

	// Maps a roll in 0..99 onto a command through cumulative thresholds.
	function automatic logic [CMD_W-1:0] pick_op(input int roll, input int t_ins,
			input int t_ups, input int t_upd, input int t_era, input int t_look,
			input int t_read);
		if (roll < t_ins)  return CMD_INSERT;
		if (roll < t_ups)  return CMD_UPSERT;
		if (roll < t_upd)  return CMD_UPDATE;
		if (roll < t_era)  return CMD_ERASE;
		if (roll < t_look) return CMD_LOOKUP;
		if (roll < t_read) return CMD_READ_POS;
		return ($urandom_range(0, 1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
	endfunction

	function automatic cmd_item_t random_cmd(input int bias);
		cmd_item_t c;
		int        roll;
		int        pos_top;
		roll = $urandom_range(0, 99);
		case (bias)
			BIAS_FILL: begin
				c.command = pick_op(roll, 40, 58, 65, 72, 82, 97);
				c.key     = pick_key(25);
			end
			BIAS_DRAIN: begin
				c.command = pick_op(roll, 10, 18, 28, 63, 78, 95);
				c.key     = pick_key(70);
			end
			default: begin
				c.command = pick_op(roll, 22, 34, 46, 62, 76, 96);
				c.key     = pick_key(50);
			end
		endcase
		c.value = $urandom();
		// Positions cluster around the fill level so both hits and the first
		// position past the end come up often.
		pos_top = (shadow_fill + 1 > DEF_MAX_ENTRIES - 1) ? DEF_MAX_ENTRIES - 1
				: shadow_fill + 1;
		if ($urandom_range(0, 3) != 0)
			c.position = POS_W'($urandom_range(0, pos_top));
		else
			c.position = POS_W'($urandom_range(0, DEF_MAX_ENTRIES - 1));
		return c;
	endfunction

	// Response side: stalls a random number of cycles before each transfer,
	// or for a long stretch when asked. Each clock step gets at most one
	// assignment to rsp_stall.
	initial begin : response_sink
		int n;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				sink_calm = ~sink_calm;
			n = pick_gap(sink_calm) + hold_cycles;
			hold_cycles = 0;
			@(negedge clk);
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
		end
	end

	// Every response transfer is matched against the oldest expectation.
	always @(posedge clk) begin
		answer_rec_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			responses_seen++;
			if (pending_answers.size() == 0) begin
				flag_mismatch($sformatf("response %0d arrived with none expected",
						responses_seen));
			end else begin
				want = pending_answers.pop_front();
				if (rsp.ok !== want.rsp.ok)
					flag_mismatch($sformatf("response %0d (op %0d key %h): ok %b, want %b",
							responses_seen, want.item.command, want.item.key,
							rsp.ok, want.rsp.ok));
				if (rsp.found_key !== want.rsp.found_key)
					flag_mismatch($sformatf("response %0d (op %0d pos %0d): found_key %h, want %h",
							responses_seen, want.item.command, want.item.position,
							rsp.found_key, want.rsp.found_key));
				if (rsp.found_value !== want.rsp.found_value)
					flag_mismatch($sformatf("response %0d (op %0d key %h): found_value %h, want %h",
							responses_seen, want.item.command, want.item.key,
							rsp.found_value, want.rsp.found_value));
				if (rsp.entry_count !== want.rsp.entry_count)
					flag_mismatch($sformatf("response %0d (op %0d): entry_count %0d, want %0d",
							responses_seen, want.item.command,
							rsp.entry_count, want.rsp.entry_count));
			end
		end
	end

	// Every command kind on a small table: both key extremes, a duplicate
	// insert, hits and misses for update, upsert, erase and lookup, reads
	// inside and past the end, erase at the front, middle and back, and the
	// two unused codes.
	task automatic test_directed_basics();
		send_fields(CMD_READ_POS, '0, '0, '0);
		send_fields(CMD_LOOKUP, '0, '0, '0);
		send_fields(CMD_INSERT, '0, '1, '0);
		send_fields(CMD_INSERT, '1, '0, '1);
		send_fields(CMD_INSERT, 32'h5A5A_A5A5, 32'h1234_5678, 6'd2);
		send_fields(CMD_INSERT, '0, 32'h0BAD_F00D, '0);
		send_fields(CMD_UPDATE, '1, 32'hDEAD_BEEF, '0);
		send_fields(CMD_UPDATE, 32'h0000_0001, 32'h1111_1111, '0);
		send_fields(CMD_UPSERT, 32'h5A5A_A5A5, 32'hA5A5_A5A5, '0);
		send_fields(CMD_UPSERT, 32'h0000_0001, 32'h0000_0007, '0);
		send_fields(CMD_LOOKUP, '1, '1, '1);
		send_fields(CMD_LOOKUP, 32'h8000_0000, '0, '0);
		send_fields(CMD_READ_POS, '1, '1, 6'd3);
		send_fields(CMD_READ_POS, '0, '0, 6'd4);
		send_fields(CMD_READ_POS, '0, '0, 6'd63);
		send_fields(CMD_ERASE, '1, '0, '0);
		send_fields(CMD_READ_POS, '0, '0, 6'd1);
		send_fields(CMD_ERASE, 32'h7FFF_FFFF, '0, '0);
		send_fields(CMD_SPARE_6, 32'h0000_0001, '1, '1);
		send_fields(CMD_SPARE_7, '1, '1, 6'd0);
		send_fields(CMD_ERASE, '0, '0, '0);
		send_fields(CMD_ERASE, 32'h0000_0001, '0, '0);
		send_fields(CMD_READ_POS, '0, '0, '0);
		wait_drained();
	endtask

	// Capacity edges on an emptied table: a capacity of one, a capacity of
	// zero that refuses inserts even when empty, and an out-of-range value
	// that must act as the full size.
	task automatic test_capacity_edges();
		while (shadow_fill > 0)
			send_fields(CMD_ERASE, shadow_keys[shadow_fill - 1], $urandom(), '0);
		wait_drained();
		write_capacity(7'd1);
		send_fields(CMD_INSERT, 32'hC0DE_0001, 32'h0000_0011, '0);
		send_fields(CMD_INSERT, 32'hC0DE_0002, 32'h0000_0022, '0);
		send_fields(CMD_UPSERT, 32'hC0DE_0002, 32'h0000_0033, '0);
		send_fields(CMD_UPSERT, 32'hC0DE_0001, 32'h0000_0044, '0);
		wait_drained();
		write_capacity(7'd0);
		send_fields(CMD_INSERT, 32'hC0DE_0003, 32'h0000_0055, '0);
		send_fields(CMD_UPDATE, 32'hC0DE_0001, 32'h0000_0066, '0);
		send_fields(CMD_ERASE, 32'hC0DE_0001, '0, '0);
		send_fields(CMD_INSERT, 32'hC0DE_0001, 32'h0000_0077, '0);
		wait_drained();
		write_capacity(7'd127);
		send_fields(CMD_INSERT, 32'hC0DE_0004, 32'h0000_0088, '0);
		send_fields(CMD_READ_POS, '0, '0, '0);
		wait_drained();
	endtask

	// Random phases under a sequence of capacity settings. The table carries
	// over from phase to phase, so it fills up to the full size, then meets
	// capacities below its count, then drains again.
	task automatic test_random_phases();
		logic [CAP_W-1:0] caps   [10] = '{7'd64, 7'd127, 7'd40, 7'd1, 7'd0,
				7'd100, 7'd2, 7'd64, 7'd17, 7'd64};
		int               biases [10] = '{BIAS_FILL, BIAS_FILL, BIAS_MIX, BIAS_DRAIN,
				BIAS_FILL, BIAS_MIX, BIAS_DRAIN, BIAS_FILL, BIAS_MIX, BIAS_DRAIN};
		foreach (caps[p]) begin
			wait_drained();
			write_capacity(caps[p]);
			repeat (100) begin
				// Now and then the sender stops until everything is answered.
				if ($urandom_range(0, 59) == 0)
					wait_drained();
				send_cmd(random_cmd(biases[p]));
			end
		end
		wait_drained();
	endtask

	// The response side holds off for a long stretch while commands keep
	// coming back to back, so the block backs up and stalls its input.
	task automatic test_backpressure();
		wait_drained();
		send_burst  = 1'b1;
		hold_cycles = LONG_HOLD;
		repeat (30)
			send_cmd(random_cmd(BIAS_MIX));
		send_burst = 1'b0;
		wait_drained();
	endtask

	initial begin : stimulus
		clk         = 1'b0;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		cmd_valid   = 1'b0;
		cmd         = '0;
		rsp_stall   = 1'b0;
		send_calm   = 1'b0;
		sink_calm   = 1'b0;
		send_burst  = 1'b0;
		hold_cycles = 0;
		mismatches  = 0;
		responses_seen = 0;
		shadow_fill = 0;
		shadow_cap  = CAP_RESET;
		foreach (key_pool[i])
			key_pool[i] = $urandom();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_basics();
		test_capacity_edges();
		test_random_phases();
		test_backpressure();

		// Anything the block sends after this point has no expectation and
		// is reported by the checker.
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("keyed_table_with_compaction verification clean");
		else
			$display("keyed_table_with_compaction verification failed");
		$finish;
	end

endmodule
